FILE: rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared types and constants for the scanner top level and its window cells.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned BASE_W     = 48;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned LANE_IDX_W = 3;
	localparam int unsigned LEN_W      = 4;
	localparam int unsigned MASK_W     = 8;
	localparam int unsigned REG_IDX_W  = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_BYTES = 2'd0,
		REG_CARE_MASK     = 2'd1,
		REG_LENGTH        = 2'd2
	} reg_index_t;

	localparam logic [WORD_W-1:0] PATTERN_RESET = '0;
	localparam logic [MASK_W-1:0] CARE_RESET    = 8'hFF;
	localparam logic [LEN_W-1:0]  LENGTH_RESET  = 4'd8;

	typedef struct packed {
		logic [WORD_W-1:0]     pattern;
		logic [MASK_W-1:0]     care;
		logic [LANE_IDX_W-1:0] len_m1;
	} scan_cfg_t;

	typedef struct packed {
		logic miss;
		logic unfilled;
	} cell_stat_t;

endpackage

FILE: rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one byte of the sliding window and its fill flag, compares the byte
// that moves in against its pattern byte and places it in the result word.
// ----------------------------------------------------------------------------
module mbps_cell #(
	parameter int unsigned CELL_INDEX = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    shift_en,
	input  logic                                    valid_in,
	input  logic [mbps_pkg::DATA_W-1:0]             byte_in,
	input  mbps_pkg::scan_cfg_t                     cfg,
	output logic [mbps_pkg::DATA_W-1:0]             byte_q,
	output logic                                    valid_q,
	output logic [mbps_pkg::WORD_W-1:0]             lane_word,
	output mbps_pkg::cell_stat_t                    stat
);

	localparam logic [mbps_pkg::LANE_IDX_W-1:0] POS = mbps_pkg::LANE_IDX_W'(CELL_INDEX);

	logic                                in_use;
	logic [mbps_pkg::LANE_IDX_W-1:0]     slot;
	logic [mbps_pkg::LANE_IDX_W+2:0]     bit_pos;
	logic [mbps_pkg::DATA_W-1:0]         pat_byte;
	logic                                care;

	assign in_use   = (POS <= cfg.len_m1);
	assign slot     = cfg.len_m1 - POS;
	assign bit_pos  = {slot, 3'b000};
	assign pat_byte = cfg.pattern[bit_pos +: mbps_pkg::DATA_W];
	assign care     = cfg.care[slot];

	assign lane_word     = in_use ? (mbps_pkg::WORD_W'(byte_in) << bit_pos) : '0;
	assign stat.miss     = in_use && care && (byte_in != pat_byte);
	assign stat.unfilled = in_use && !valid_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q  <= '0;
			valid_q <= 1'b0;
		end else if (shift_en) begin
			byte_q  <= byte_in;
			valid_q <= valid_in;
		end
	end

endmodule

FILE: rtl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Scans a byte stream grouped into regions for a pattern with wildcard bytes.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle while s_tready is high. Each
// transfer on the input is shifted into a row of window cells, and the masked
// compare of the whole window against the pattern is done in the same cycle;
// a match is registered in the output register, or in the one skid entry
// while the output register holds an untaken result, so the input keeps going
// while a result waits. s_tready falls only while the skid entry is occupied.
// Configuration writes are taken at any time and are meant for an idle scanner.
module masked_byte_pattern_scanner #(
	parameter int unsigned MAX_PATTERN  = 8,
	parameter int unsigned ADDRESS_BITS = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [55:0]                          s_tdata,   // data_byte, region_base
	input  logic [0:0]                           s_tuser,   // region_start
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [111:0]                         m_tdata,   // match_address, matched_bytes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbps_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [mbps_pkg::WORD_W-1:0]          cfg_data
);

	localparam logic [mbps_pkg::LEN_W-1:0] MAX_LEN = mbps_pkg::LEN_W'(MAX_PATTERN);

	logic [mbps_pkg::WORD_W-1:0]     pattern_q;
	logic [mbps_pkg::MASK_W-1:0]     care_q;
	logic [mbps_pkg::LEN_W-1:0]      len_q;
	logic [mbps_pkg::LEN_W-1:0]      len_eff;
	mbps_pkg::scan_cfg_t             cfg;

	logic [mbps_pkg::DATA_W-1:0]     data_byte;
	logic                            region_start;
	logic [mbps_pkg::BASE_W-1:0]     region_base;
	logic [ADDRESS_BITS-1:0]         base_in;

	logic                            accept;
	logic [ADDRESS_BITS-1:0]         addr_q;
	logic [ADDRESS_BITS-1:0]         this_addr;
	logic [ADDRESS_BITS-1:0]         match_addr;
	logic [mbps_pkg::BASE_W-1:0]     match_out;

	logic [MAX_PATTERN-1:0]          valid_in;
	logic [MAX_PATTERN-1:0]          valid_q;
	logic [mbps_pkg::DATA_W-1:0]     byte_in [MAX_PATTERN];
	logic [mbps_pkg::DATA_W-1:0]     byte_q  [MAX_PATTERN];
	logic [mbps_pkg::WORD_W-1:0]     lane_word [MAX_PATTERN];
	mbps_pkg::cell_stat_t            stat [MAX_PATTERN];

	logic [mbps_pkg::WORD_W-1:0]     packed_bytes;
	logic                            hit;
	logic                            new_result;
	logic                            out_take;

	logic                            out_valid_q;
	logic [mbps_pkg::BASE_W-1:0]     out_addr_q;
	logic [mbps_pkg::WORD_W-1:0]     out_bytes_q;
	logic                            skid_valid_q;
	logic [mbps_pkg::BASE_W-1:0]     skid_addr_q;
	logic [mbps_pkg::WORD_W-1:0]     skid_bytes_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= mbps_pkg::PATTERN_RESET;
			care_q    <= mbps_pkg::CARE_RESET;
			len_q     <= mbps_pkg::LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mbps_pkg::REG_PATTERN_BYTES: pattern_q <= cfg_data;
				mbps_pkg::REG_CARE_MASK:     care_q    <= cfg_data[mbps_pkg::MASK_W-1:0];
				mbps_pkg::REG_LENGTH:        len_q     <= cfg_data[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			len_eff = mbps_pkg::LEN_W'(1);
		end else if (len_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = len_q;
		end
	end

	assign cfg.pattern = pattern_q;
	assign cfg.care    = care_q;
	assign cfg.len_m1  = mbps_pkg::LANE_IDX_W'(len_eff - mbps_pkg::LEN_W'(1));

	assign data_byte    = s_tdata[7:0];
	assign region_base  = s_tdata[55:8];
	assign region_start = s_tuser[0];
	assign base_in      = ADDRESS_BITS'(region_base);

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	assign this_addr  = region_start ? base_in : addr_q;
	assign match_addr = this_addr
		- {{(ADDRESS_BITS-mbps_pkg::LANE_IDX_W){1'b0}}, cfg.len_m1};
	assign match_out  = mbps_pkg::BASE_W'(match_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (accept) begin
			addr_q <= this_addr + {{(ADDRESS_BITS-1){1'b0}}, 1'b1};
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign valid_in[i] = 1'b1;
			assign byte_in[i]  = data_byte;
		end else begin : g_body
			assign valid_in[i] = valid_q[i-1] && !region_start;
			assign byte_in[i]  = byte_q[i-1];
		end

		mbps_cell #(
			.CELL_INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (accept),
			.valid_in  (valid_in[i]),
			.byte_in   (byte_in[i]),
			.cfg       (cfg),
			.byte_q    (byte_q[i]),
			.valid_q   (valid_q[i]),
			.lane_word (lane_word[i]),
			.stat      (stat[i])
		);
	end

	always_comb begin
		packed_bytes = '0;
		hit          = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			packed_bytes = packed_bytes | lane_word[i];
			if (stat[i].miss || stat[i].unfilled) begin
				hit = 1'b0;
			end
		end
	end

	assign new_result = accept && hit;
	assign out_take   = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (new_result) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_addr_q  <= skid_addr_q;
				out_bytes_q <= skid_bytes_q;
			end
		end else if (new_result) begin
			if (!out_valid_q || out_take) begin
				out_addr_q  <= match_out;
				out_bytes_q <= packed_bytes;
			end else begin
				skid_addr_q  <= match_out;
				skid_bytes_q <= packed_bytes;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_bytes_q, out_addr_q};

`ifndef SYNTHESIS
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while the output register is empty");

	a_fill_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && region_start) |=> (valid_q[0] && $countones(valid_q) == 1))
		else $error("window fill did not restart at a region start");

	a_fill_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q + 1'b1) & valid_q) == '0)
		else $error("window fill flags are not contiguous from the newest byte");

	a_address_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !region_start) |=>
			(addr_q == $past(addr_q) + {{(ADDRESS_BITS-1){1'b0}}, 1'b1}))
		else $error("byte address did not advance by one");
`endif

endmodule

FILE: verif/masked_byte_pattern_scanner_tb.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner testbench
// Streams memory bytes in regions through the scanner under a series of
// pattern, care mask and length settings. Every accepted byte is run through
// a local model of the window compare, and each match transfer is checked
// field by field against the oldest predicted hit. Both stream sides idle at
// random, except in every fourth phase, where neither side idles.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mbps_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int WINDOW_DEPTH  = 8;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 45;
	localparam int DRAIN_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct {
		logic [mbps_pkg::DATA_W-1:0] data;
		logic                        start;
		logic [mbps_pkg::BASE_W-1:0] base;
	} scan_item_t;

	typedef struct {
		logic [mbps_pkg::BASE_W-1:0] addr;
		logic [mbps_pkg::WORD_W-1:0] bytes;
	} scan_hit_t;

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [55:0]  s_tdata   = '0;	// data_byte, region_base
	logic [0:0]   s_tuser   = '0;	// region_start
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [111:0] m_tdata;			// match_address, matched_bytes
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [mbps_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [mbps_pkg::WORD_W-1:0]    cfg_data  = '0;

	masked_byte_pattern_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	scan_item_t pending_bytes[$];
	scan_hit_t  expected_hits[$];

	logic [mbps_pkg::WORD_W-1:0] pat_reg;
	logic [mbps_pkg::MASK_W-1:0] care_reg;
	logic [mbps_pkg::LEN_W-1:0]  len_reg;
	logic [mbps_pkg::DATA_W-1:0] win_bytes[WINDOW_DEPTH];
	int                          fill;
	logic [mbps_pkg::BASE_W-1:0] cur_base;
	logic [mbps_pkg::BASE_W-1:0] byte_pos;

	logic in_taken  = 1'b0;
	logic cfg_taken = 1'b0;
	logic no_idle   = 1'b0;
	int   in_gap    = 0;
	int   out_stall = 0;
	int   items_pushed   = 0;
	int   items_accepted = 0;
	int   hits_checked   = 0;
	int   since_activity = 0;
	int   cycle_count    = 0;
	int   mismatches     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int eff_len(input logic [mbps_pkg::LEN_W-1:0] l);
		if (l == 0)
			return 1;
		if (l > WINDOW_DEPTH)
			return WINDOW_DEPTH;
		return int'(l);
	endfunction

	function automatic void reset_model();
		pat_reg  = mbps_pkg::PATTERN_RESET;
		care_reg = mbps_pkg::CARE_RESET;
		len_reg  = mbps_pkg::LENGTH_RESET;
		foreach (win_bytes[i])
			win_bytes[i] = '0;
		fill     = 0;
		cur_base = '0;
		byte_pos = '0;
	endfunction

	function automatic void apply_reg(input logic [mbps_pkg::REG_IDX_W-1:0] idx,
			input logic [mbps_pkg::WORD_W-1:0] d);
		case (idx)
			mbps_pkg::REG_PATTERN_BYTES: pat_reg = d;
			mbps_pkg::REG_CARE_MASK:     care_reg = d[mbps_pkg::MASK_W-1:0];
			mbps_pkg::REG_LENGTH:        len_reg = d[mbps_pkg::LEN_W-1:0];
			default: ;
		endcase
	endfunction

	// Shifts one byte into the window and predicts the hit it completes, if any.
	function automatic void scan_byte(input logic [mbps_pkg::DATA_W-1:0] d, input logic st,
			input logic [mbps_pkg::BASE_W-1:0] b);
		int                          len;
		logic                        hit;
		logic [mbps_pkg::WORD_W-1:0] packed_win;
		logic [mbps_pkg::BASE_W-1:0] at;
		scan_hit_t                   h;
		if (st) begin
			cur_base = b;
			byte_pos = '0;
			fill     = 0;
		end
		for (int i = WINDOW_DEPTH - 1; i > 0; i--)
			win_bytes[i] = win_bytes[i-1];
		win_bytes[0] = d;
		if (fill < WINDOW_DEPTH)
			fill++;
		at       = byte_pos;
		byte_pos = byte_pos + 1'b1;
		len = eff_len(len_reg);
		if (fill < len)
			return;
		hit        = 1'b1;
		packed_win = '0;
		for (int j = 0; j < len; j++) begin
			if (care_reg[j] && win_bytes[len-1-j] != pat_reg[8*j +: 8])
				hit = 1'b0;
			packed_win[8*j +: 8] = win_bytes[len-1-j];
		end
		if (!hit)
			return;
		h.addr  = cur_base + at - mbps_pkg::BASE_W'(len - 1);
		h.bytes = packed_win;
		expected_hits = {expected_hits, h};
	endfunction

	task automatic report_mismatch(input string what,
			input logic [mbps_pkg::WORD_W-1:0] got,
			input logic [mbps_pkg::WORD_W-1:0] want);
		$display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : observe
		scan_hit_t h;
		cycle_count++;
		since_activity++;
		in_taken  <= s_tvalid && s_tready;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				since_activity = 0;
				if (expected_hits.size() == 0) begin
					report_mismatch("match transfer with no hit predicted",
						{16'h0, m_tdata[47:0]}, '0);
				end else begin
					h = expected_hits.pop_front();
					hits_checked++;
					if (m_tdata[47:0] != h.addr)
						report_mismatch("match_address", {16'h0, m_tdata[47:0]},
							{16'h0, h.addr});
					if (m_tdata[111:48] != h.bytes)
						report_mismatch("matched_bytes", m_tdata[111:48], h.bytes);
				end
			end
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata[7:0], s_tuser[0], s_tdata[55:8]);
				items_accepted++;
				since_activity = 0;
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(negedge clk) begin : drive_bytes
		scan_item_t it;
		if (s_tvalid && !in_taken) begin
			// Hold the offered byte until it is taken.
		end else if (in_gap > 0) begin
			in_gap--;
			s_tvalid <= 1'b0;
		end else if (pending_bytes.size() != 0) begin
			it = pending_bytes.pop_front();
			s_tvalid <= 1'b1;
			s_tdata  <= {it.base, it.data};
			s_tuser  <= it.start;
			in_gap = rand_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				out_stall = rand_gap();
		end
	end

	task automatic write_reg(input logic [mbps_pkg::REG_IDX_W-1:0] idx,
			input logic [mbps_pkg::WORD_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_byte(input logic [mbps_pkg::DATA_W-1:0] d, input logic st,
			input logic [mbps_pkg::BASE_W-1:0] b);
		scan_item_t it;
		it.data  = d;
		it.start = st;
		it.base  = b;
		pending_bytes = {pending_bytes, it};
		items_pushed++;
	endtask

	function automatic logic [mbps_pkg::BASE_W-1:0] pick_base();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return '1 - mbps_pkg::BASE_W'($urandom_range(0, 12));
			default: return r[mbps_pkg::BASE_W-1:0];
		endcase
	endfunction

	task automatic emit_byte(input logic [mbps_pkg::DATA_W-1:0] d, inout int reg_left);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (reg_left == 0) begin
			reg_left = $urandom_range(1, 24);
			queue_byte(d, 1'b1, pick_base());
		end else begin
			queue_byte(d, 1'b0, r[mbps_pkg::BASE_W-1:0]);
		end
		reg_left--;
	endtask

	// Zero bytes before any region start, a region just below the top of the
	// address space, and a region restart in the middle of a full window.
	task automatic queue_directed();
		for (int i = 0; i < 9; i++)
			queue_byte(8'h00, 1'b0, pick_base());
		queue_byte(8'h00, 1'b1, 48'hFFFF_FFFF_FFFD);
		for (int i = 0; i < 8; i++)
			queue_byte(8'h00, 1'b0, '1);
		queue_byte(8'hFF, 1'b0, '0);
		queue_byte(8'h00, 1'b1, '0);
		for (int i = 0; i < 5; i++)
			queue_byte(8'h00, 1'b0, '1);
	endtask

	// Mostly copies of the current pattern with random wildcard content and the
	// odd corrupted byte, mixed with near misses and plain random bytes.
	task automatic queue_random(input int n);
		int reg_left;
		int len;
		int sent;
		int unsigned c;
		logic [mbps_pkg::DATA_W-1:0] d;
		reg_left = 0;
		sent     = 0;
		len      = eff_len(len_reg);
		while (sent < n) begin
			c = $urandom_range(0, 9);
			if (c < 4) begin
				for (int j = 0; j < len; j++) begin
					d = mbps_pkg::DATA_W'($urandom_range(0, 255));
					if (care_reg[j] && $urandom_range(0, 19) != 0)
						d = pat_reg[8*j +: 8];
					emit_byte(d, reg_left);
				end
				sent += len;
			end else begin
				d = mbps_pkg::DATA_W'($urandom_range(0, 255));
				if (c < 6)
					d = pat_reg[8*$urandom_range(0, WINDOW_DEPTH - 1) +: 8];
				emit_byte(d, reg_left);
				sent++;
			end
		end
	endtask

	task automatic configure(input int p);
		logic [63:0] r1;
		logic [63:0] r2;
		logic [63:0] r3;
		logic [mbps_pkg::MASK_W-1:0] care;
		logic [mbps_pkg::LEN_W-1:0]  len;
		r1   = {$urandom, $urandom};
		r2   = {$urandom, $urandom};
		r3   = {$urandom, $urandom};
		care = r2[mbps_pkg::MASK_W-1:0];
		len  = mbps_pkg::LEN_W'($urandom_range(0, 15));
		case (p)
			1: len = 4'd0;
			2: begin
				care = '0;
				len  = 4'd8;
			end
			3: begin
				care = '1;
				len  = 4'd15;
			end
			4: begin
				r1   = '1;
				care = '1;
				len  = 4'd1;
			end
			5: len = 4'd9;
			default: if ($urandom_range(0, 2) == 0) care = '1;
		endcase
		write_reg(mbps_pkg::REG_PATTERN_BYTES, r1);
		write_reg(mbps_pkg::REG_CARE_MASK, {r2[63:mbps_pkg::MASK_W], care});
		write_reg(mbps_pkg::REG_LENGTH, {r3[63:mbps_pkg::LEN_W], len});
		if (p == 4 || $urandom_range(0, 3) == 0)
			write_reg(REG_UNMAPPED, {$urandom, $urandom});
	endtask

	task automatic wait_idle();
		while (items_accepted != items_pushed)
			@(negedge clk);
		while (expected_hits.size() != 0 && since_activity < DRAIN_LIMIT)
			@(negedge clk);
		if (expected_hits.size() != 0) begin
			report_mismatch("predicted hits never transferred",
				mbps_pkg::WORD_W'(expected_hits.size()), '0);
			expected_hits.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				configure(p);
			no_idle = (p % 4 == 3);
			if (p == 0)
				queue_directed();
			else
				queue_random(PHASE_ITEMS);
			wait_idle();
		end
		$display("Scanned %0d bytes in %0d setting phases and compared %0d matches.",
			items_accepted, PHASES, hits_checked);
		$display("Lengths from 0 to 15, empty and full care masks, address wrap and "
			, "writes to the unmapped index were covered.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
